// ===== sv/stpe_pkg.sv =====
// Package for the state table with priority eviction.
// Request and result structs, command and status codes, sizing constants.
package stpe_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int OVERHEAD_DEF = 64;
  localparam int MEM_W = 18;
  localparam logic [MEM_W-1:0] MEM_RESET = 18'd2048;
  localparam logic [15:0] LOCAL_PRIO = 16'hFFFF;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_FREE  = 3'd1;
  localparam logic [2:0] CMD_FREEP = 3'd2;
  localparam logic [2:0] CMD_FIND  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOMAT = 3'd1;
  localparam logic [2:0] ST_AMBIG = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] id_word_high;
    logic [63:0] id_word_middle;
    logic [31:0] id_word_low;
    logic [4:0]  prefix_length;
    logic [15:0] state_length;
    logic [15:0] retention_priority;
  } stpe_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [4:0]       match_count;
    logic [3:0]       match_slot;
    logic [MEM_W-1:0] memory_remaining;
  } stpe_res_t;

endpackage

// ===== sv/state_table_priority_eviction_top.sv =====
// State table with retention-priority eviction, top level.
// Depends on stpe_pkg; entry fields held in one synchronous memory.
//
// Usage: pulse start with a request on in_req while busy is low. The block
// scans every slot of its entry memory, one slot a cycle, then acts on the
// result in an update state that writes or frees a slot. out_valid marks
// the result on out_res for exactly one cycle. After the scan, whose reads
// pass through the registered memory output, come the update state and an
// output state; the strobe is registered from the output state.
// busy stays high until the strobe cycle, so a new request can be accepted
// in the strobe cycle; no new request is taken while the block scans.
// cfg_we with cfg_wdata writes the state memory size; it reloads the
// free-memory count only on a clear request.
// Reset (synchronous, rst_n low) empties the table, clears the age counter
// and sets the size to 2048 bytes. Entry memory contents are undefined after
// reset and are read only for valid slots. The receiver cannot stall: each
// result is taken in its strobe cycle.
module state_table_priority_eviction_top #(
  parameter int SLOTS = stpe_pkg::SLOTS_DEF,
  parameter int STATE_OVERHEAD = stpe_pkg::OVERHEAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  stpe_pkg::stpe_req_t   in_req,
  output logic                  out_valid,
  output stpe_pkg::stpe_res_t   out_res,
  input  logic                  cfg_we,
  input  logic [stpe_pkg::MEM_W-1:0] cfg_wdata
);
  import stpe_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] mid;
    logic [31:0] lo;
    logic [15:0] len;
    logic [15:0] prio;
    logic [15:0] age;
  } entry_t;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  entry_t mem [SLOTS];
  entry_t rd_q;

  logic [1:0]  st_r, st_nxt;
  stpe_req_t   req_r;
  logic [SLOTS-1:0] valid_r;
  logic [15:0] next_age_r;
  logic [MEM_W-1:0] size_r, left_r;
  logic [SW:0] addr_r;          // read address, counts to SLOTS
  logic [SW:0] rslot_r;         // slot of data in rd_q
  logic        rd_v_r;
  logic        have_r;
  logic [SW-1:0] best_r;
  logic [16:0] bkey_r;
  logic [15:0] bdist_r;
  logic [15:0] blen_r;
  logic [CW-1:0] cnt_r;
  logic        free_found_r;
  logic [SW-1:0] free_slot_r;
  stpe_res_t   res_r, res_nxt;
  logic        out_v_r;

  // prefix mask over the 160-bit identifier, byte granularity
  logic [4:0]   plen;
  logic [159:0] pmask, id_in, id_rd;
  always_comb begin
    plen = (req_r.prefix_length > 5'd20) ? 5'd20 : req_r.prefix_length;
    for (int i = 0; i < 20; i++) begin
      pmask[159-8*i -: 8] = (5'(i) < plen) ? 8'hFF : 8'h00;
    end
  end
  assign id_in = {req_r.id_word_high, req_r.id_word_middle, req_r.id_word_low};
  assign id_rd = {rd_q.hi, rd_q.mid, rd_q.lo};

  logic [SW-1:0] rs;
  logic          rvalid, match;
  logic [16:0]   key;
  logic [15:0]   age_gap;
  assign rs      = rslot_r[SW-1:0];
  assign rvalid  = rd_v_r && valid_r[rs];
  assign match   = ((id_rd ^ id_in) & pmask) == '0;
  assign key     = (rd_q.prio == LOCAL_PRIO) ? 17'd0 : {1'b0, rd_q.prio} + 17'd1;
  assign age_gap = next_age_r - rd_q.age;

  // memory return and consumption
  logic [MEM_W+1:0] ret_sum, cost;
  logic [MEM_W-1:0] ret_val;
  assign ret_sum = {2'b0, left_r} + {4'b0, blen_r} + (MEM_W+2)'(STATE_OVERHEAD);
  assign ret_val = (ret_sum > {2'b0, size_r}) ? size_r : ret_sum[MEM_W-1:0];
  assign cost = {4'b0, req_r.state_length} + (MEM_W+2)'(STATE_OVERHEAD);

  logic wr_en;
  entry_t wr_data;
  assign wr_data = '{hi: req_r.id_word_high, mid: req_r.id_word_middle,
                     lo: req_r.id_word_low, len: req_r.state_length,
                     prio: req_r.retention_priority, age: next_age_r};
  assign wr_en = (st_r == S_ACT) && (req_r.command == CMD_ADD) && free_found_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[free_slot_r] <= wr_data;
    rd_q <= mem[addr_r[SW-1:0]];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) st_nxt = S_SCAN;
      S_SCAN: if (rd_v_r && rslot_r == (SW+1)'(SLOTS-1)) st_nxt = S_ACT;
      S_ACT:  st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // result of the request, taken at the end of the update cycle
  always_comb begin
    res_nxt = '0;
    unique case (req_r.command)
      CMD_ADD: begin
        if (free_found_r) res_nxt.match_slot = 4'(free_slot_r);
        else res_nxt.status = ST_FULL;
      end
      CMD_FREE: begin
        if (have_r) res_nxt.match_slot = 4'(best_r);
        else res_nxt.status = ST_EMPTY;
      end
      CMD_FREEP, CMD_FIND: begin
        res_nxt.match_count = (int'(cnt_r) > 31) ? 5'd31 : 5'(cnt_r);
        if (cnt_r == '0) res_nxt.status = ST_NOMAT;
        else begin
          res_nxt.match_slot = 4'(best_r);
          if (req_r.command == CMD_FREEP && cnt_r != CW'(1)) res_nxt.status = ST_AMBIG;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      valid_r <= '0;
      next_age_r <= '0;
      size_r <= MEM_RESET;
      left_r <= MEM_RESET;
      out_v_r <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_v_r <= (st_r == S_OUT);
      if (cfg_we) size_r <= cfg_wdata;
      rd_v_r <= (st_r == S_SCAN) && (addr_r < (SW+1)'(SLOTS));
      if (st_r == S_ACT) begin
        res_r <= res_nxt;
        unique case (req_r.command)
          CMD_ADD: begin
            if (free_found_r) begin
              valid_r[free_slot_r] <= 1'b1;
              next_age_r <= next_age_r + 16'd1;
              left_r <= ({2'b0, left_r} > cost) ? MEM_W'({2'b0, left_r} - cost) : '0;
            end
          end
          CMD_FREE: begin
            if (have_r) begin
              valid_r[best_r] <= 1'b0;
              left_r <= ret_val;
            end
          end
          CMD_FREEP: begin
            if (cnt_r == CW'(1)) begin
              valid_r[best_r] <= 1'b0;
              left_r <= ret_val;
            end
          end
          CMD_CLEAR: begin
            valid_r <= '0;
            left_r <= size_r;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers: request capture and scan accumulators
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && start) begin
      req_r <= in_req;
      addr_r <= '0;
      have_r <= 1'b0;
      cnt_r <= '0;
      free_found_r <= 1'b0;
      best_r <= '0;
      free_slot_r <= '0;
    end else if (st_r == S_SCAN) begin
      if (addr_r < (SW+1)'(SLOTS)) addr_r <= addr_r + (SW+1)'(1);
      rslot_r <= addr_r;
      if (rd_v_r) begin
        if (!valid_r[rs] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_slot_r <= rs;
        end
        if (rvalid) begin
          if (req_r.command == CMD_FREE) begin
            if (!have_r || key < bkey_r || (key == bkey_r && age_gap > bdist_r)) begin
              have_r <= 1'b1; best_r <= rs; bkey_r <= key;
              bdist_r <= age_gap; blen_r <= rd_q.len;
            end
          end else if (match) begin
            cnt_r <= cnt_r + CW'(1);
            if (!have_r || age_gap < bdist_r) begin
              have_r <= 1'b1; best_r <= rs;
              bdist_r <= age_gap; blen_r <= rd_q.len;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_res = res_r;
    out_res.memory_remaining = left_r;
  end
  assign out_valid = out_v_r;
  assign busy = (st_r != S_IDLE);

endmodule
